FILE: design/text_token_lexer_assert.svh
// Assertion macros for the text token lexer checker.
// No dependencies; included by the checker file only.
`ifndef TEXT_TOKEN_LEXER_ASSERT_SVH
`define TEXT_TOKEN_LEXER_ASSERT_SVH

// Same-cycle implication, ignored while reset is asserted
`define TTL_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("text_token_lexer: check failed");

// Next-cycle implication, ignored while reset is asserted
`define TTL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("text_token_lexer: check failed");

// Condition that must hold in the cycle after a reset edge
`define TTL_ASSERT_AFTER_RESET(lbl, clk, rstn, cons) \
    lbl: assert property (@(posedge clk) (!rstn) |=> (cons)) \
        else $error("text_token_lexer: check failed");

`endif

FILE: design/ttl_pkg.sv
// Types, character constants and classification helpers for the text token lexer.
// No dependencies; used by every module of the lexer.
`default_nettype none

package ttl_pkg;

    // Record kinds as reported on the result channel
    typedef enum logic [2:0] {
        KIND_SPACE   = 3'd0,
        KIND_INTEGER = 3'd1,
        KIND_DECIMAL = 3'd2,
        KIND_WORD    = 3'd3,
        KIND_PUNCT   = 3'd4,
        KIND_SYMBOL  = 3'd5
    } kind_t;

    // Kind of the token currently being collected
    typedef enum logic [2:0] {
        OPEN_NONE   = 3'd0,
        OPEN_SPACE  = 3'd1,
        OPEN_NUMBER = 3'd2,
        OPEN_WORD   = 3'd3,
        OPEN_GLYPH  = 3'd4
    } open_t;

    localparam logic [7:0]  CH_ZERO   = 8'h30;
    localparam logic [7:0]  CH_NINE   = 8'h39;
    localparam logic [7:0]  CH_DOT    = 8'h2E;
    localparam logic [7:0]  CH_COMMA  = 8'h2C;
    localparam logic [7:0]  CH_APOS   = 8'h27;
    localparam logic [7:0]  CH_HYPHEN = 8'h2D;

    localparam logic [62:0] VALUE_MAX = {63{1'b1}};
    localparam logic [31:0] LEN_MAX   = 32'hFFFF_FFFF;

    // Result queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } in_t;

    typedef struct packed {
        kind_t       token_kind;
        logic [31:0] token_start;
        logic [31:0] token_length;
        logic [7:0]  glyph_first;
        logic [7:0]  glyph_second;
        logic [62:0] integer_value;
        logic        number_overflow;
        logic        last_of_run;
    } out_t;

    // Records produced by one accepted byte, in order
    typedef struct packed {
        logic [1:0] count;
        out_t       rec0;
        out_t       rec1;
    } push_t;

    function automatic logic blank_char(logic [7:0] c);
        return (c == 8'd32) || (c inside {[8'd9:8'd13]});
    endfunction

    function automatic logic numeral_char(logic [7:0] c);
        return c inside {[CH_ZERO:CH_NINE]};
    endfunction

    function automatic logic letter_char(logic [7:0] c);
        return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    function automatic logic mark_char(logic [7:0] c);
        return c inside {[8'd33:8'd47], [8'd58:8'd64], [8'd91:8'd96], [8'd123:8'd126]};
    endfunction

    // Glyphs that count as punctuation when they stand alone
    function automatic logic is_sentence(logic [7:0] c);
        return c inside {8'h2E, 8'h21, 8'h2C, 8'h3F, 8'h3B, 8'h3A};
    endfunction

    // Record for the token that is closed from the given open state
    function automatic out_t close_rec(open_t kind, logic [31:0] start, logic [31:0] len,
                                       logic [62:0] acc, logic ovf, logic dot,
                                       logic [7:0] glyph);
        out_t r;
        r = '0;
        r.token_start  = start;
        r.token_length = len;
        case (kind)
            OPEN_SPACE: begin
                r.token_kind = KIND_SPACE;
            end
            OPEN_NUMBER: begin
                if (dot) begin
                    r.token_kind = KIND_DECIMAL;
                end else begin
                    r.token_kind      = KIND_INTEGER;
                    r.integer_value   = acc;
                    r.number_overflow = ovf;
                end
            end
            OPEN_WORD: begin
                r.token_kind = KIND_WORD;
            end
            OPEN_GLYPH: begin
                r.token_kind   = is_sentence(glyph) ? KIND_PUNCT : KIND_SYMBOL;
                r.token_length = 32'd1;
                r.glyph_first  = glyph;
            end
            default: begin
                r = '0;
            end
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: design/ttl_lexer_core.sv
// Lexer state and per-byte next-state logic; emits up to two records per byte.
// Depends on ttl_pkg.
`default_nettype none

module ttl_lexer_core #(
    parameter int POSITION_BITS = 32
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_fire,
    input  wire ttl_pkg::in_t  in_item,
    output ttl_pkg::push_t     push
);

    ttl_pkg::open_t             open_kind_reg, open_kind_next;
    logic [POSITION_BITS-1:0]   run_start_reg, run_start_next;
    logic [POSITION_BITS-1:0]   byte_pos_reg, byte_pos_next;
    logic [31:0]                run_len_reg, run_len_next;
    logic [62:0]                acc_reg, acc_next;
    logic                       ovf_reg, ovf_next;
    logic                       dot_reg, dot_next;
    logic [7:0]                 glyph_reg, glyph_next;

    logic [7:0]                 c;
    logic                       c_space, c_digit, c_alpha, c_punct;
    logic                       cont;
    logic                       close_a;
    logic                       pair;
    ttl_pkg::out_t              rec_a, rec_b, rec_e, second;
    logic                       b_valid, e_valid;
    ttl_pkg::open_t             open_after;
    ttl_pkg::open_t             open_mid;
    logic [POSITION_BITS-1:0]   start_mid;
    logic [31:0]                len_mid;
    logic [62:0]                acc_mid;
    logic                       ovf_mid, dot_mid;
    logic [7:0]                 glyph_mid;
    logic [66:0]                prod;
    ttl_pkg::push_t             push_c;

    assign c       = in_item.text_byte;
    assign c_space = ttl_pkg::blank_char(c);
    assign c_digit = ttl_pkg::numeral_char(c);
    assign c_alpha = ttl_pkg::letter_char(c);
    assign c_punct = ttl_pkg::mark_char(c);

    // acc * 10 + digit, wide enough to see overflow past 2^63-1
    assign prod = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1) + 67'(c[3:0]);

    // Does this byte extend the open run
    always_comb begin
        case (open_kind_reg)
            ttl_pkg::OPEN_SPACE:  cont = c_space;
            ttl_pkg::OPEN_NUMBER: cont = c_digit || (c == ttl_pkg::CH_DOT) ||
                                         (c == ttl_pkg::CH_COMMA);
            ttl_pkg::OPEN_WORD:   cont = c_alpha || (c == ttl_pkg::CH_APOS) ||
                                         (c == ttl_pkg::CH_HYPHEN);
            default:              cont = 1'b0;
        endcase
    end

    // Closing of the open token, then continue or open, then end-of-text close
    always_comb begin
        pair    = (open_kind_reg == ttl_pkg::OPEN_GLYPH) && c_punct;
        close_a = (open_kind_reg != ttl_pkg::OPEN_NONE) &&
                  ((open_kind_reg == ttl_pkg::OPEN_GLYPH) || !cont);

        rec_a = ttl_pkg::close_rec(open_kind_reg, 32'(run_start_reg), run_len_reg,
                                   acc_reg, ovf_reg, dot_reg, glyph_reg);
        if (pair) begin
            rec_a              = '0;
            rec_a.token_kind   = ttl_pkg::KIND_SYMBOL;
            rec_a.token_start  = 32'(run_start_reg);
            rec_a.token_length = 32'd2;
            rec_a.glyph_first  = glyph_reg;
            rec_a.glyph_second = c;
        end

        open_after = close_a ? ttl_pkg::OPEN_NONE : open_kind_reg;

        open_mid  = open_after;
        start_mid = run_start_reg;
        len_mid   = run_len_reg;
        acc_mid   = acc_reg;
        ovf_mid   = ovf_reg;
        dot_mid   = dot_reg;
        glyph_mid = glyph_reg;
        b_valid   = 1'b0;
        rec_b     = '0;

        if (!pair) begin
            if (open_after != ttl_pkg::OPEN_NONE) begin
                // run goes on
                if (run_len_reg != ttl_pkg::LEN_MAX) begin
                    len_mid = run_len_reg + 32'd1;
                end
                if (open_after == ttl_pkg::OPEN_NUMBER) begin
                    if (c == ttl_pkg::CH_DOT) begin
                        dot_mid = 1'b1;
                    end else if (c_digit && !ovf_reg) begin
                        if (prod[66:63] != 4'd0) begin
                            ovf_mid = 1'b1;
                            acc_mid = ttl_pkg::VALUE_MAX;
                        end else begin
                            acc_mid = prod[62:0];
                        end
                    end
                end
            end else begin
                // new token starts at this byte
                start_mid = byte_pos_reg;
                len_mid   = 32'd1;
                if (c_space) begin
                    open_mid = ttl_pkg::OPEN_SPACE;
                end else if (c_digit) begin
                    open_mid = ttl_pkg::OPEN_NUMBER;
                    acc_mid  = 63'(c[3:0]);
                    ovf_mid  = 1'b0;
                    dot_mid  = 1'b0;
                end else if (c_alpha) begin
                    open_mid = ttl_pkg::OPEN_WORD;
                end else if (c_punct) begin
                    open_mid  = ttl_pkg::OPEN_GLYPH;
                    glyph_mid = c;
                end else begin
                    b_valid            = 1'b1;
                    rec_b.token_kind   = ttl_pkg::KIND_SYMBOL;
                    rec_b.token_start  = 32'(byte_pos_reg);
                    rec_b.token_length = 32'd1;
                    rec_b.glyph_first  = c;
                end
            end
        end

        e_valid = in_item.end_of_text && (open_mid != ttl_pkg::OPEN_NONE);
        rec_e   = ttl_pkg::close_rec(open_mid, 32'(start_mid), len_mid, acc_mid,
                                     ovf_mid, dot_mid, glyph_mid);
    end

    // Pack the records in order and mark the final one
    always_comb begin
        second = b_valid ? rec_b : rec_e;
        push_c = '0;
        if (close_a) begin
            push_c.rec0  = rec_a;
            push_c.rec1  = second;
            push_c.count = (b_valid || e_valid) ? 2'd2 : 2'd1;
        end else begin
            push_c.rec0  = second;
            push_c.rec1  = '0;
            push_c.count = (b_valid || e_valid) ? 2'd1 : 2'd0;
        end
        if (push_c.count == 2'd2) begin
            push_c.rec1.last_of_run = 1'b1;
        end else begin
            push_c.rec0.last_of_run = 1'b1;
        end
        if (!in_fire) begin
            push_c.count = 2'd0;
        end
    end

    assign push = push_c;

    // Next state; end of text returns everything to reset values
    always_comb begin
        if (in_item.end_of_text) begin
            open_kind_next = ttl_pkg::OPEN_NONE;
            run_start_next = '0;
            byte_pos_next  = '0;
            run_len_next   = '0;
            acc_next       = '0;
            ovf_next       = 1'b0;
            dot_next       = 1'b0;
            glyph_next     = '0;
        end else begin
            open_kind_next = open_mid;
            run_start_next = start_mid;
            byte_pos_next  = byte_pos_reg + 1'b1;
            run_len_next   = len_mid;
            acc_next       = acc_mid;
            ovf_next       = ovf_mid;
            dot_next       = dot_mid;
            glyph_next     = glyph_mid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_kind_reg <= ttl_pkg::OPEN_NONE;
            run_start_reg <= '0;
            byte_pos_reg  <= '0;
            run_len_reg   <= '0;
            acc_reg       <= '0;
            ovf_reg       <= 1'b0;
            dot_reg       <= 1'b0;
            glyph_reg     <= '0;
        end else if (in_fire) begin
            open_kind_reg <= open_kind_next;
            run_start_reg <= run_start_next;
            byte_pos_reg  <= byte_pos_next;
            run_len_reg   <= run_len_next;
            acc_reg       <= acc_next;
            ovf_reg       <= ovf_next;
            dot_reg       <= dot_next;
            glyph_reg     <= glyph_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/ttl_rec_queue.sv
// Small result queue: takes up to two records per cycle, hands out one.
// Depends on ttl_pkg.
`default_nettype none

module ttl_rec_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire ttl_pkg::push_t push,
    input  wire logic           pop,
    output ttl_pkg::out_t       head,
    output logic                not_empty,
    output logic                room_two
);

    ttl_pkg::out_t                mem_reg [ttl_pkg::QUEUE_DEPTH];
    logic [ttl_pkg::QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ttl_pkg::QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [ttl_pkg::QUEUE_AW:0]   count_reg, count_next;
    logic [ttl_pkg::QUEUE_AW-1:0] wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;
    assign head         = mem_reg[rd_ptr_reg];
    assign not_empty    = (count_reg != '0);
    assign room_two     = (count_reg <= (ttl_pkg::QUEUE_AW+1)'(ttl_pkg::QUEUE_DEPTH - 2));

    // Pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg + ttl_pkg::QUEUE_AW'(push.count);
        rd_ptr_next = rd_ptr_reg + ttl_pkg::QUEUE_AW'(pop);
        count_next  = count_reg + (ttl_pkg::QUEUE_AW+1)'(push.count)
                                - (ttl_pkg::QUEUE_AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Record storage, no reset needed
    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push.rec0;
        end
        if (push.count == 2'd2) begin
            mem_reg[wr_ptr_plus1] <= push.rec1;
        end
    end

endmodule

`default_nettype wire

FILE: design/text_token_lexer.sv
// Records of an accepted byte are written into the result queue and offered from its head.
// Throughput: one byte per cycle while s_ready is high; a byte that closes one token
// and yields another record leaves two records for the one-record result port.
// A four-record queue sits behind the lexer; s_ready drops when fewer than two are free.
// Reset: synchronous, active low on aresetn; clears lexer state and empties the queue.
// Depends on ttl_pkg, ttl_lexer_core and ttl_rec_queue.
`default_nettype none

module text_token_lexer #(
    parameter int POSITION_BITS = 32
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire ttl_pkg::in_t  s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output ttl_pkg::out_t      m_data
);

    logic           in_fire;
    logic           pop;
    logic           room_two;
    ttl_pkg::push_t push;

    assign in_fire = s_valid && s_ready;
    assign pop     = m_valid && m_ready;
    assign s_ready = room_two;

    // Byte classification and token state
    ttl_lexer_core #(
        .POSITION_BITS(POSITION_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (in_fire),
        .in_item (s_data),
        .push    (push)
    );

    // Records wait here for the result side
    ttl_rec_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .pop       (pop),
        .head      (m_data),
        .not_empty (m_valid),
        .room_two  (room_two)
    );

endmodule

`default_nettype wire

FILE: design/ttl_checker.sv
// Port-level checks for the text token lexer, bound to the top level.
// Depends on ttl_pkg and text_token_lexer_assert.svh.
`default_nettype none

`include "text_token_lexer_assert.svh"

module ttl_checker (
    input wire logic          aclk,
    input wire logic          aresetn,
    input wire logic          s_valid,
    input wire logic          s_ready,
    input wire ttl_pkg::in_t  s_data,
    input wire logic          m_valid,
    input wire logic          m_ready,
    input wire ttl_pkg::out_t m_data
);

    logic non_integer;
    logic value_clear;
    logic value_at_max;
    logic s_stall;
    logic m_stall;

    assign non_integer  = (m_data.token_kind != ttl_pkg::KIND_INTEGER);
    assign value_clear  = (m_data.integer_value == '0) && !m_data.number_overflow;
    assign value_at_max = (m_data.integer_value == ttl_pkg::VALUE_MAX);
    assign s_stall      = s_valid && !s_ready;
    assign m_stall      = m_valid && !m_ready;

    // Queue comes out of reset empty
    `TTL_ASSERT_AFTER_RESET(a_reset_empty, aclk, aresetn, !m_valid)

    // A stalled item stays offered and unchanged
    `TTL_ASSERT_NEXT(a_hold, aclk, aresetn, m_stall, m_valid && $stable(m_data))

    // A waiting input item stays offered and unchanged
    `TTL_ASSERT_NEXT(a_in_hold, aclk, aresetn, s_stall, s_valid && $stable(s_data))

    // Only integer records carry a value or an overflow flag
    `TTL_ASSERT_SAME(a_value_zero, aclk, aresetn, m_valid && non_integer, value_clear)

    // Overflow pins the value at its maximum
    `TTL_ASSERT_SAME(a_ovf_max, aclk, aresetn, m_valid && m_data.number_overflow, value_at_max)

endmodule

bind text_token_lexer ttl_checker u_ttl_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
